// ----- design/ipv6p_pkg.sv -----
// ----------------------------------------------------------------------------
// IPv6 prefix text parser package
// Shared types and status codes for the netblock text parser.
// ----------------------------------------------------------------------------
package ipv6p_pkg;

	localparam int unsigned NumBytes = 16;

	typedef enum logic [1:0] {
		MODE_HEX = 2'd0,
		MODE_DOT = 2'd1,
		MODE_PFX = 2'd2
	} mode_t;

	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_EMPTY       = 4'd1;
	localparam logic [3:0] ST_MULTI_GAP   = 4'd2;
	localparam logic [3:0] ST_TOO_MANY    = 4'd3;
	localparam logic [3:0] ST_BAD_CHAR    = 4'd4;
	localparam logic [3:0] ST_HEX_LONG    = 4'd5;
	localparam logic [3:0] ST_DEC_MANY    = 4'd6;
	localparam logic [3:0] ST_DEC_LZ      = 4'd7;
	localparam logic [3:0] ST_DEC_BIG     = 4'd8;
	localparam logic [3:0] ST_DEC_FEW     = 4'd9;
	localparam logic [3:0] ST_TOO_FEW     = 4'd10;
	localparam logic [3:0] ST_PFX_LZ      = 4'd11;
	localparam logic [3:0] ST_PFX_BIG     = 4'd12;
	localparam logic [3:0] ST_PFX_CHAR    = 4'd13;
	localparam logic [3:0] ST_PFX_MISSING = 4'd14;

	typedef logic [NumBytes-1:0][7:0] bytes_t;

	// running parse state
	typedef struct packed {
		logic [4:0]  widx;
		logic [4:0]  gidx;
		logic        gap;
		logic [2:0]  dcnt;
		logic [15:0] hacc;
		logic [8:0]  dacc;
		mode_t       mode;
		logic [2:0]  dots;
		logic [3:0]  err;
		logic        first;
		logic        cpend;
	} pstate_t;

	// result word handed to the output stage
	typedef struct packed {
		logic [127:0] addr;
		logic [7:0]   plen;
		logic [3:0]   status;
	} result_t;

endpackage

// ----- design/ipv6p_step.sv -----
// ----------------------------------------------------------------------------
// IPv6 prefix text parser step logic
// Next parse state and address store for one character, plus the final
// gap expansion when the character ends the string.
// ----------------------------------------------------------------------------
module ipv6p_step (
	input  logic [7:0]         ch,
	input  logic               last,
	input  ipv6p_pkg::pstate_t cur,
	input  ipv6p_pkg::bytes_t  mem,
	output ipv6p_pkg::pstate_t nxt,
	output ipv6p_pkg::bytes_t  mem_nxt,
	output ipv6p_pkg::result_t res
);

	function automatic logic [3:0] hexval(input logic [7:0] c, output logic ok);
		ok = 1'b1;
		if (c >= 8'h30 && c <= 8'h39) return c[3:0];
		if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
			return 4'(c[3:0] + 4'd9);
		ok = 1'b0;
		return 4'd0;
	endfunction

	ipv6p_pkg::pstate_t s;
	ipv6p_pkg::bytes_t  m;
	ipv6p_pkg::bytes_t  x;
	logic [3:0]  e;
	logic [3:0]  hv;
	logic        hok;
	logic        is_dig;
	logic [3:0]  dig;
	logic [4:0]  off;
	logic [4:0]  src;
	logic [4:0]  k5;
	logic [2:0]  n;

	// decimal digit into the running value
	function automatic void ddig(inout ipv6p_pkg::pstate_t t, inout logic [3:0] er,
		input logic [3:0] d, input logic [8:0] lim, input logic [3:0] lz,
		input logic [3:0] big);
		logic [12:0] w;
		w = 13'(t.dacc) * 13'd10 + 13'(d);
		if (t.dcnt != 3'd0 && t.dacc == 9'd0) er = lz;
		else begin
			t.dcnt = 3'(t.dcnt + 3'd1);
			if (w > 13'(lim)) er = big;
			else t.dacc = w[8:0];
		end
	endfunction

	always_comb begin
		s = cur;
		m = mem;
		e = ipv6p_pkg::ST_OK;
		{hok, hv} = 5'd0;
		hv = hexval(ch, hok);
		is_dig = ch >= 8'h30 && ch <= 8'h39;
		dig = ch[3:0];
		off = 5'd0;
		src = 5'd0;
		k5 = 5'd0;
		n = 3'd0;
		x = mem;
		res = '0;
		// consume one character unless an error is already latched
		if (cur.err == ipv6p_pkg::ST_OK) begin
			if (s.cpend) begin
				s.cpend = 1'b0;
				if (ch != 8'h3a) e = ipv6p_pkg::ST_EMPTY;
			end else if (s.mode == ipv6p_pkg::MODE_HEX && ch == 8'h3a && s.first) begin
				if (last) e = ipv6p_pkg::ST_EMPTY;
				else s.cpend = 1'b1;
			end
			if (e == ipv6p_pkg::ST_OK && !(cur.cpend == 1'b0 && s.cpend)) begin
				unique case (s.mode)
					ipv6p_pkg::MODE_HEX: begin
						if (ch == 8'h3a) begin
							if (s.dcnt == 3'd0) begin
								if (s.gap) e = ipv6p_pkg::ST_MULTI_GAP;
								else begin
									s.gap = 1'b1;
									s.gidx = s.widx;
								end
							end else if (s.widx[4]) e = ipv6p_pkg::ST_TOO_MANY;
							else begin
								m[s.widx[3:0]] = s.hacc[15:8];
								m[4'(s.widx[3:0] + 4'd1)] = s.hacc[7:0];
								s.widx = 5'(s.widx + 5'd2);
								s.hacc = 16'd0;
								s.dcnt = 3'd0;
							end
						end else if (ch == 8'h2e) begin
							if (s.widx > 5'd12) e = ipv6p_pkg::ST_TOO_MANY;
							else begin
								n = s.dcnt;
								s.dcnt = 3'd0;
								s.dacc = 9'd0;
								s.mode = ipv6p_pkg::MODE_DOT;
								// re-read up to four held hex digits as decimal
								for (int i = 3; i >= 0; i--) begin
									if (e == ipv6p_pkg::ST_OK && 3'(i) < n) begin
										if (s.hacc[4*i +: 4] > 4'd9) e = ipv6p_pkg::ST_BAD_CHAR;
										else ddig(s, e, s.hacc[4*i +: 4], 9'd255,
											ipv6p_pkg::ST_DEC_LZ, ipv6p_pkg::ST_DEC_BIG);
									end
								end
								if (e == ipv6p_pkg::ST_OK) begin
									s.hacc = 16'd0;
									if (s.dcnt == 3'd0) e = ipv6p_pkg::ST_EMPTY;
									else if (s.dots >= 3'd4) e = ipv6p_pkg::ST_DEC_MANY;
									else begin
										m[s.widx[3:0]] = s.dacc[7:0];
										s.widx = 5'(s.widx + 5'd1);
										s.dots = 3'(s.dots + 3'd1);
										s.dacc = 9'd0;
										s.dcnt = 3'd0;
									end
								end
							end
						end else if (ch == 8'h2f) begin
							if (s.dcnt == 3'd0) begin
								if (!(s.gap && s.gidx == s.widx)) e = ipv6p_pkg::ST_EMPTY;
							end else if (s.widx[4]) e = ipv6p_pkg::ST_TOO_MANY;
							else begin
								m[s.widx[3:0]] = s.hacc[15:8];
								m[4'(s.widx[3:0] + 4'd1)] = s.hacc[7:0];
								s.widx = 5'(s.widx + 5'd2);
								s.hacc = 16'd0;
								s.dcnt = 3'd0;
							end
							if (e == ipv6p_pkg::ST_OK) begin
								if (!s.gap) begin
									if (!s.widx[4]) e = ipv6p_pkg::ST_TOO_FEW;
								end else if (s.widx[4]) e = ipv6p_pkg::ST_TOO_MANY;
								s.mode = ipv6p_pkg::MODE_PFX;
								s.dacc = 9'd0;
								s.dcnt = 3'd0;
							end
						end else if (!hok) e = ipv6p_pkg::ST_BAD_CHAR;
						else begin
							s.hacc = {s.hacc[11:0], hv};
							s.dcnt = 3'(s.dcnt + 3'd1);
							if (s.dcnt > 3'd4) e = ipv6p_pkg::ST_HEX_LONG;
						end
					end
					ipv6p_pkg::MODE_DOT: begin
						if (ch == 8'h2e || ch == 8'h2f) begin
							if (s.dcnt == 3'd0) e = ipv6p_pkg::ST_EMPTY;
							else if (s.dots >= 3'd4) e = ipv6p_pkg::ST_DEC_MANY;
							else begin
								m[s.widx[3:0]] = s.dacc[7:0];
								s.widx = 5'(s.widx + 5'd1);
								s.dots = 3'(s.dots + 3'd1);
								s.dacc = 9'd0;
								s.dcnt = 3'd0;
							end
							if (e == ipv6p_pkg::ST_OK && ch == 8'h2f) begin
								if (s.dots < 3'd4) e = ipv6p_pkg::ST_DEC_FEW;
								else begin
									if (!s.gap) begin
										if (!s.widx[4]) e = ipv6p_pkg::ST_TOO_FEW;
									end else if (s.widx[4]) e = ipv6p_pkg::ST_TOO_MANY;
									s.mode = ipv6p_pkg::MODE_PFX;
									s.dacc = 9'd0;
									s.dcnt = 3'd0;
								end
							end
						end else if (is_dig) ddig(s, e, dig, 9'd255,
							ipv6p_pkg::ST_DEC_LZ, ipv6p_pkg::ST_DEC_BIG);
						else e = ipv6p_pkg::ST_BAD_CHAR;
					end
					default: begin
						if (is_dig) ddig(s, e, dig, 9'd128,
							ipv6p_pkg::ST_PFX_LZ, ipv6p_pkg::ST_PFX_BIG);
						else e = ipv6p_pkg::ST_PFX_CHAR;
					end
				endcase
			end
			s.err = e;
		end
		s.first = 1'b0;

		// close the string on the last character
		if (last) begin
			res.plen = 8'd128;
			e = s.err;
			if (e == ipv6p_pkg::ST_OK) begin
				if (s.mode == ipv6p_pkg::MODE_PFX) begin
					if (s.dcnt == 3'd0) e = ipv6p_pkg::ST_PFX_MISSING;
					else res.plen = s.dacc[7:0];
				end else begin
					if (s.mode == ipv6p_pkg::MODE_HEX) begin
						if (s.dcnt == 3'd0) begin
							if (!(s.gap && s.gidx == s.widx)) e = ipv6p_pkg::ST_EMPTY;
						end else if (s.widx[4]) e = ipv6p_pkg::ST_TOO_MANY;
						else begin
							m[s.widx[3:0]] = s.hacc[15:8];
							m[4'(s.widx[3:0] + 4'd1)] = s.hacc[7:0];
							s.widx = 5'(s.widx + 5'd2);
						end
					end else begin
						if (s.dcnt == 3'd0) e = ipv6p_pkg::ST_EMPTY;
						else if (s.dots >= 3'd4) e = ipv6p_pkg::ST_DEC_MANY;
						else begin
							m[s.widx[3:0]] = s.dacc[7:0];
							s.widx = 5'(s.widx + 5'd1);
							if (3'(s.dots + 3'd1) < 3'd4) e = ipv6p_pkg::ST_DEC_FEW;
						end
					end
					if (e == ipv6p_pkg::ST_OK) begin
						if (!s.gap) begin
							if (!s.widx[4]) e = ipv6p_pkg::ST_TOO_FEW;
						end else if (s.widx[4]) e = ipv6p_pkg::ST_TOO_MANY;
					end
				end
			end
			// expand the gap: bytes at or past the gap move right by the gap size
			x = m;
			if (e == ipv6p_pkg::ST_OK && s.gap) begin
				off = 5'(5'd16 - s.widx);
				for (int k = 0; k < 16; k++) begin
					k5 = 5'(k);
					src = 5'(k5 - off);
					if (k5 < s.gidx) x[k] = m[k];
					else if (k5 < 5'(s.gidx + off)) x[k] = 8'd0;
					else x[k] = m[src[3:0]];
				end
			end
			m = x;
			res.status = e;
			for (int k = 0; k < 16; k++) res.addr[127 - 8*k -: 8] = x[k];
			if (e != ipv6p_pkg::ST_OK) begin
				res.addr = '0;
				res.plen = 8'd0;
			end
			s = '0;
			s.mode = ipv6p_pkg::MODE_HEX;
			s.first = 1'b1;
		end
		nxt = s;
		mem_nxt = m;
	end

endmodule

// ----- design/ipv6_prefix_text_parser_core.sv -----
// ----------------------------------------------------------------------------
// IPv6 prefix text parser
// Parses an IPv6 netblock string, one character per word, into a 128-bit
// address, a prefix length and a status code.
// ----------------------------------------------------------------------------
// Input channel s_axis: one ASCII character per word, tlast on the final one.
// Output channel m_axis: one word per string, sent after the tlast word.
// A character is taken into an input register, then one pass of step logic
// updates the running parse state and the 16-byte address store; on the last
// character that same pass expands the "::" gap and fills the result
// register. A character can be accepted every cycle unless the stall below holds it.
// The tlast word is registered in the input register, and its result in the
// result register, where it holds until it is taken on m_axis.
// While the output waits on m_axis_tready, the result register holds; the
// input register keeps filling until a pending tlast word meets a full
// result register, then s_axis_tready drops until the result is taken.
// Reset clears all parse state; the address store needs no reset, since
// an unwritten byte is never shown with a good status.
// Status 0 means ok; any other value is the first error in the string.
module ipv6_prefix_text_parser_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // ch[7:0]
	input  logic         s_axis_tlast,  // last
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// addr_high[63:0], addr_low[127:64], prefix_len[135:128], status[139:136]
	output logic [143:0] m_axis_tdata
);

	logic               v_s1;
	logic [7:0]         ch_s1;
	logic               last_s1;
	ipv6p_pkg::pstate_t st_q;
	ipv6p_pkg::bytes_t  mem_q;
	ipv6p_pkg::pstate_t st_d;
	ipv6p_pkg::bytes_t  mem_d;
	ipv6p_pkg::result_t res_d;
	ipv6p_pkg::result_t res_q;
	logic               ov_q;
	logic               adv;

	// stage 1 advances when valid, unless it holds a last word and a full output is not taken
	assign adv = v_s1 && !(last_s1 && ov_q && !m_axis_tready);
	assign s_axis_tready = !v_s1 || adv;

	ipv6p_step u_step (
		.ch(ch_s1), .last(last_s1), .cur(st_q), .mem(mem_q),
		.nxt(st_d), .mem_nxt(mem_d), .res(res_d)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (s_axis_tready) v_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			st_q.mode <= ipv6p_pkg::MODE_HEX;
			st_q.first <= 1'b1;
		end else if (adv) st_q <= st_d;
	end
	always_ff @(posedge clk) begin
		if (adv) mem_q <= mem_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (adv && last_s1) ov_q <= 1'b1;
		else if (m_axis_tready) ov_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (adv && last_s1) res_q <= res_d;
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = {4'd0, res_q.status, res_q.plen, res_q.addr[63:0],
		res_q.addr[127:64]};

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[139:136] != ipv6p_pkg::ST_OK
		|-> m_axis_tdata[135:0] == '0)
		else $error("error result carries data");
	a_plen: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[135:128] <= 8'd128)
		else $error("prefix length out of range");
	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> st_q.first && st_q.err == ipv6p_pkg::ST_OK)
		else $error("parse state not cleared after string");
`endif

endmodule
